>>> rtl/second_chance_cache_set_defines.svh
// Assertion macros for the second-chance cache set.
// Included by the RTL files that carry concurrent checks; uses clk_i and rst_ni.
`ifndef SECOND_CHANCE_CACHE_SET_DEFINES_SVH
`define SECOND_CHANCE_CACHE_SET_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCC_ASSERT(name, prop, msg)
`define SCC_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> rtl/scc_pkg.sv
// Shared types and constants of the second-chance cache set.
// No dependencies; used by the controller, the datapath and the top level.
package scc_pkg;

  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned CMD_BITS   = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_GET   = 3'd0,
    CMD_PUT   = 3'd1,
    CMD_DEL   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_PROBE = 3'd4
  } scc_cmd_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] write_value;
  } scc_req_t;

  typedef struct packed {
    logic                  status;
    logic [VALUE_BITS-1:0] read_value;
    logic                  ref_bit;
    logic                  evicted;
  } scc_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_WALK,
    S_FILL,
    S_RESP
  } scc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic walk;
    logic fill;
  } scc_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic put_miss;
    logic full;
    logic evict;
  } scc_stat_t;

endpackage

>>> rtl/scc_ctrl.sv
// Sequencing state machine of the second-chance cache set.
// Depends on scc_pkg for the state enum and the command and status structs.
module scc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output scc_pkg::scc_ctrl_t ctrl_o,
  input  scc_pkg::scc_stat_t stat_i
);

  scc_pkg::scc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scc_pkg::S_IDLE: begin
        if (start_i) state_d = scc_pkg::S_LOOKUP;
      end
      scc_pkg::S_LOOKUP: begin
        state_d = scc_pkg::S_EXEC;
      end
      scc_pkg::S_EXEC: begin
        if (stat_i.put_miss) begin
          state_d = stat_i.full ? scc_pkg::S_WALK : scc_pkg::S_FILL;
        end else begin
          state_d = scc_pkg::S_RESP;
        end
      end
      scc_pkg::S_WALK: begin
        if (stat_i.evict) state_d = scc_pkg::S_FILL;
      end
      scc_pkg::S_FILL: begin
        state_d = scc_pkg::S_RESP;
      end
      scc_pkg::S_RESP: begin
        state_d = scc_pkg::S_IDLE;
      end
      default: begin
        state_d = scc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      scc_pkg::S_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      scc_pkg::S_LOOKUP: ctrl_o.lookup = 1'b1;
      scc_pkg::S_EXEC:   ctrl_o.exec   = 1'b1;
      scc_pkg::S_WALK:   ctrl_o.walk   = 1'b1;
      scc_pkg::S_FILL:   ctrl_o.fill   = 1'b1;
      scc_pkg::S_RESP:   done_o        = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/scc_dp.sv
// Datapath of the second-chance cache set: tags, valid and reference bits,
// age queue, value memory and result registers. Depends on scc_pkg.
`include "second_chance_cache_set_defines.svh"

module scc_dp #(
  parameter int unsigned WAYS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scc_pkg::scc_ctrl_t       ctrl_i,
  output scc_pkg::scc_stat_t       stat_o,
  input  scc_pkg::scc_req_t        req_i,
  output scc_pkg::scc_rsp_t        rsp_o,
  input  logic [$clog2(WAYS+1)-1:0] limit_i
);

  localparam int unsigned IW = $clog2(WAYS);
  localparam int unsigned CW = $clog2(WAYS + 1);

  scc_pkg::scc_req_t req_q;

  logic [WAYS-1:0]              valid_q;
  logic [WAYS-1:0]              ref_q;
  logic [scc_pkg::KEY_BITS-1:0] key_q [WAYS];
  logic [IW-1:0]                queue_q [WAYS];
  logic [IW-1:0]                queue_d [WAYS];
  logic [IW-1:0]                queue_up [WAYS];
  logic [CW-1:0]                count_q;

  logic [scc_pkg::VALUE_BITS-1:0] val_mem [WAYS];
  logic [scc_pkg::VALUE_BITS-1:0] mem_rdata_q;

  logic          hit_q;
  logic [IW-1:0] hit_way_q;

  logic status_q, rbit_q, ev_q, rd_en_q;

  logic [WAYS-1:0] match;
  logic [IW-1:0]   match_way;
  logic [WAYS-1:0] qmatch;
  logic            qfound;
  logic [IW-1:0]   qpos;
  logic [WAYS-1:0] free_vec, free_oh;
  logic            free_any;
  logic [IW-1:0]   free_way;

  logic          is_get, is_put, is_del, is_clear, is_probe;
  logic          del_do, fill_do, walk_evict, walk_rotate, mem_we, mem_re;
  logic [IW-1:0] head, last_idx, fill_idx, mem_waddr;

  assign is_get   = (req_q.cmd == scc_pkg::CMD_GET);
  assign is_put   = (req_q.cmd == scc_pkg::CMD_PUT);
  assign is_del   = (req_q.cmd == scc_pkg::CMD_DEL);
  assign is_clear = (req_q.cmd == scc_pkg::CMD_CLEAR);
  assign is_probe = (req_q.cmd == scc_pkg::CMD_PROBE);

  // Parallel tag compare; keys are unique among valid ways.
  always_comb begin
    match_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_q[w] && (key_q[w] == req_q.key);
      if (match[w]) match_way = match_way | IW'(w);
    end
  end

  // Position of the hit way in the age queue, for delete.
  always_comb begin
    qpos = '0;
    for (int i = 0; i < WAYS; i++) begin
      qmatch[i] = (i < int'(count_q)) && (queue_q[i] == hit_way_q);
      if (qmatch[i]) qpos = qpos | IW'(i);
    end
  end
  assign qfound = |qmatch;

  // Lowest free way.
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + WAYS'(1));
  assign free_any = |free_vec;
  always_comb begin
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (free_oh[w]) free_way = free_way | IW'(w);
    end
  end

  assign head        = queue_q[0];
  assign last_idx    = IW'(count_q - CW'(1));
  assign fill_idx    = IW'(count_q);
  assign walk_evict  = ctrl_i.walk && !ref_q[head];
  assign walk_rotate = ctrl_i.walk && ref_q[head];
  assign del_do      = ctrl_i.exec && is_del && hit_q;
  assign fill_do     = ctrl_i.fill && free_any && (count_q < CW'(WAYS));
  assign mem_we      = (ctrl_i.exec && is_put && hit_q) || fill_do;
  assign mem_waddr   = ctrl_i.fill ? free_way : hit_way_q;
  assign mem_re      = ctrl_i.exec && is_get && hit_q;

  assign stat_o.put_miss = is_put && !hit_q;
  assign stat_o.full     = (count_q >= limit_i);
  assign stat_o.evict    = !ref_q[head];

  for (genvar i = 0; i < WAYS; i++) begin : g_up
    if (i < WAYS - 1) begin : g_next
      assign queue_up[i] = queue_q[i+1];
    end else begin : g_last
      assign queue_up[i] = queue_q[i];
    end
  end

  always_comb begin
    queue_d = queue_q;
    if (del_do && qfound) begin
      for (int i = 0; i < WAYS; i++) begin
        if ((i >= int'(qpos)) && ((i + 1) < int'(count_q))) queue_d[i] = queue_up[i];
      end
    end
    if (ctrl_i.walk) begin
      for (int i = 0; i < WAYS; i++) begin
        if ((i + 1) < int'(count_q)) queue_d[i] = queue_up[i];
      end
      // A referenced head gets its second chance at the tail.
      if (walk_rotate) queue_d[last_idx] = head;
    end
    if (fill_do) queue_d[fill_idx] = free_way;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) req_q <= req_i;
    if (ctrl_i.lookup) begin
      hit_q     <= |match;
      hit_way_q <= match_way;
    end
    queue_q <= queue_d;
    if (fill_do) key_q[free_way] <= req_q.key;
    if (ctrl_i.exec && (is_get || is_put) && hit_q) ref_q[hit_way_q] <= 1'b1;
    if (walk_rotate) ref_q[head] <= 1'b0;
    if (fill_do) ref_q[free_way] <= 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      if (ctrl_i.exec && is_clear) begin
        valid_q <= '0;
        count_q <= '0;
      end
      if (del_do) begin
        valid_q[hit_way_q] <= 1'b0;
        if (qfound) count_q <= count_q - CW'(1);
      end
      if (walk_evict) begin
        valid_q[head] <= 1'b0;
        count_q       <= count_q - CW'(1);
      end
      if (fill_do) begin
        valid_q[free_way] <= 1'b1;
        count_q           <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) val_mem[mem_waddr] <= req_q.write_value;
    if (mem_re) mem_rdata_q <= val_mem[hit_way_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      status_q <= scc_pkg::STATUS_OK;
      rbit_q   <= 1'b0;
      ev_q     <= 1'b0;
      rd_en_q  <= 1'b0;
    end
    if (ctrl_i.exec) begin
      status_q <= ((is_get || is_del || is_probe) && !hit_q) ? scc_pkg::STATUS_MISS
                                                              : scc_pkg::STATUS_OK;
      rbit_q   <= is_probe && hit_q && ref_q[hit_way_q];
      rd_en_q  <= is_get && hit_q;
    end
    if (walk_evict) ev_q <= 1'b1;
  end

  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rd_en_q ? mem_rdata_q : '0;
  assign rsp_o.ref_bit    = rbit_q;
  assign rsp_o.evicted    = ev_q;

  `SCC_ASSERT(a_count_tracks_valid, $countones(valid_q) == int'(count_q), "count mismatch")
  `SCC_ASSERT(a_walk_needs_entries, !ctrl_i.walk || (count_q >= CW'(2)), "walk on short queue")
  `SCC_ASSERT(a_unique_tags, !ctrl_i.lookup || $onehot0(match), "duplicate tag in set")
  `SCC_ASSERT_NEXT(a_get_sets_ref, ctrl_i.exec && is_get && hit_q, ref_q[hit_way_q],
                   "get hit left reference bit clear")

endmodule

>>> rtl/second_chance_cache_set.sv
// A result strobes on done_o in RESP, after LOOKUP and EXEC; a put of a new key adds
// the FILL state, plus WALK states (one age-queue entry per cycle) when full.
// A new item is accepted only when idle, after the result of the last one is shown.
// Reset: all ways invalid, entry count zero, ways_in_use 8; no clearing pass is needed.
// The result is shown for one cycle with done_o; the receiver cannot stall it.
module second_chance_cache_set #(
  parameter int unsigned WAYS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  scc_pkg::scc_req_t req_i,
  output logic              done_o,
  output scc_pkg::scc_rsp_t rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CW = $clog2(WAYS + 1);
  localparam logic [1:0] ADDR_WAYS_IN_USE = 2'd0;

  logic [3:0]         ways_q;
  logic [CW-1:0]      limit;
  scc_pkg::scc_ctrl_t ctrl;
  scc_pkg::scc_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= 4'd8;
    end else if (psel && penable && pwrite && (paddr == ADDR_WAYS_IN_USE)) begin
      ways_q <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WAYS_IN_USE) ? 32'(ways_q) : '0;

  // The limit is clamped to the range two to WAYS.
  always_comb begin
    if (32'(ways_q) > 32'(WAYS)) begin
      limit = CW'(WAYS);
    end else if (ways_q < 4'd2) begin
      limit = CW'(2);
    end else begin
      limit = CW'(ways_q);
    end
  end

  scc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctrl_o  (ctrl),
    .stat_i  (stat)
  );

  scc_dp #(
    .WAYS (WAYS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .limit_i (limit)
  );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for second_chance_cache_set: get, put, delete, clear and probe
// beats against a cycle-free predictor of the set, with the way limit reprogrammed over APB.
// Depends on scc_pkg and the second_chance_cache_set RTL.
module tb_top;

  localparam int unsigned WAYS = 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd0;
  localparam logic [scc_pkg::CMD_BITS-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [scc_pkg::CMD_BITS-1:0] CMD_UNUSED_LAST = 3'd7;
  localparam logic [scc_pkg::KEY_BITS-1:0] KEY_ALL_ONES = '1;
  localparam logic [scc_pkg::VALUE_BITS-1:0] VALUE_ALL_ONES = '1;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  scc_pkg::scc_req_t req_i;
  logic done_o;
  scc_pkg::scc_rsp_t rsp_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  second_chance_cache_set #(
    .WAYS(WAYS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted contents of the set.
  logic                           way_ok   [WAYS];
  logic [scc_pkg::KEY_BITS-1:0]   way_tag  [WAYS];
  logic [scc_pkg::VALUE_BITS-1:0] way_data [WAYS];
  logic                           way_ref  [WAYS];
  logic [2:0]                     age_order[WAYS];
  int unsigned                    live_count;
  logic [3:0]                     way_limit;

  scc_pkg::scc_rsp_t cache_rsp_q[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned max_gap;
  logic [scc_pkg::KEY_BITS-1:0] key_pool[16];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Removes one slot of the age order and shifts the newer entries down.
  function automatic void drop_age_slot(int unsigned pos);
    if (pos >= live_count) return;
    for (int unsigned i = pos; i + 1 < live_count; i++) age_order[i] = age_order[i + 1];
    live_count--;
  endfunction

  function automatic scc_pkg::scc_rsp_t cache_predict(scc_pkg::scc_req_t r);
    scc_pkg::scc_rsp_t rsp;
    int hit;
    int slot;
    int unsigned lim;
    int unsigned w;
    logic hunting;
    rsp = '0;
    hit = -1;
    for (int i = 0; i < WAYS; i++) begin
      if (hit < 0 && way_ok[i] && way_tag[i] == r.key) hit = i;
    end
    lim = (way_limit < 2) ? 2 : ((way_limit > WAYS) ? WAYS : way_limit);
    case (r.cmd)
      scc_pkg::CMD_GET: begin
        if (hit < 0) begin
          rsp.status = scc_pkg::STATUS_MISS;
        end else begin
          way_ref[hit] = 1'b1;
          rsp.read_value = way_data[hit];
        end
      end
      scc_pkg::CMD_PUT: begin
        if (hit >= 0) begin
          way_data[hit] = r.write_value;
          way_ref[hit] = 1'b1;
        end else begin
          // Full set: referenced entries lose their bit and go to the tail,
          // the first unreferenced one from the head is evicted.
          if (live_count >= lim) begin
            hunting = 1'b1;
            for (int s = 0; s <= WAYS && hunting && live_count > 0; s++) begin
              w = age_order[0];
              drop_age_slot(0);
              if (!way_ref[w]) begin
                way_ok[w] = 1'b0;
                rsp.evicted = 1'b1;
                hunting = 1'b0;
              end else begin
                way_ref[w] = 1'b0;
                age_order[live_count] = w[2:0];
                live_count++;
              end
            end
          end
          slot = -1;
          for (int i = 0; i < WAYS; i++) begin
            if (slot < 0 && !way_ok[i]) slot = i;
          end
          if (slot >= 0 && live_count < WAYS) begin
            way_ok[slot] = 1'b1;
            way_tag[slot] = r.key;
            way_data[slot] = r.write_value;
            way_ref[slot] = 1'b0;
            age_order[live_count] = slot[2:0];
            live_count++;
          end
        end
      end
      scc_pkg::CMD_DEL: begin
        if (hit < 0) begin
          rsp.status = scc_pkg::STATUS_MISS;
        end else begin
          hunting = 1'b1;
          for (int unsigned i = 0; i < live_count && hunting; i++) begin
            if (age_order[i] == hit[2:0]) begin
              drop_age_slot(i);
              hunting = 1'b0;
            end
          end
          way_ok[hit] = 1'b0;
        end
      end
      scc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < WAYS; i++) way_ok[i] = 1'b0;
        live_count = 0;
      end
      scc_pkg::CMD_PROBE: begin
        if (hit < 0) rsp.status = scc_pkg::STATUS_MISS;
        else rsp.ref_bit = way_ref[hit];
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    scc_pkg::scc_rsp_t want;
    if (rst_ni && done_o) begin
      if (cache_rsp_q.size() == 0) begin
        $error("result beat with no prediction pending");
        error_count++;
      end else begin
        want = cache_rsp_q.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_o.status);
          error_count++;
        end
        if (rsp_o.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, rsp_o.read_value);
          error_count++;
        end
        if (rsp_o.ref_bit !== want.ref_bit) begin
          $error("ref_bit: expected %0d, actual %0d", want.ref_bit, rsp_o.ref_bit);
          error_count++;
        end
        if (rsp_o.evicted !== want.evicted) begin
          $error("evicted: expected %0d, actual %0d", want.evicted, rsp_o.evicted);
          error_count++;
        end
      end
    end
  end

  // Sends one command beat. Called and left at a falling edge; start stays high
  // afterwards so that back-to-back beats need no second assignment in one step.
  task automatic send_item(input logic [scc_pkg::CMD_BITS-1:0] cmd,
                           input logic [scc_pkg::KEY_BITS-1:0] key,
                           input logic [scc_pkg::VALUE_BITS-1:0] value);
    scc_pkg::scc_req_t r;
    int unsigned gap;
    r.cmd = cmd;
    r.key = key;
    r.write_value = value;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    cache_rsp_q.push_back(cache_predict(r));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (cache_rsp_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes ways_in_use with random upper data bits, then reads it back.
  task automatic set_way_limit(input logic [3:0] limit);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_WAYS_IN_USE;
    pwdata <= {28'($urandom()), limit};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    way_limit = limit;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[3:0] !== limit) begin
      $error("ways_in_use: expected %0d, actual %0d", limit, prdata[3:0]);
      error_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_basic_ops();
    max_gap = 6;
    send_item(scc_pkg::CMD_PUT, '0, '0);
    send_item(scc_pkg::CMD_PUT, KEY_ALL_ONES, VALUE_ALL_ONES);
    send_item(scc_pkg::CMD_GET, '0, VALUE_ALL_ONES);
    send_item(scc_pkg::CMD_GET, KEY_ALL_ONES, '0);
    send_item(scc_pkg::CMD_PROBE, KEY_ALL_ONES, '0);
    send_item(scc_pkg::CMD_PROBE, key_pool[3], '0);
    send_item(scc_pkg::CMD_GET, key_pool[4], '0);
    send_item(scc_pkg::CMD_PUT, KEY_ALL_ONES, {$urandom(), $urandom()});
    send_item(scc_pkg::CMD_DEL, '0, '0);
    send_item(scc_pkg::CMD_DEL, '0, '0);
    send_item(CMD_UNUSED_FIRST, KEY_ALL_ONES, VALUE_ALL_ONES);
    send_item(CMD_UNUSED_FIRST + 3'd1, KEY_ALL_ONES, '0);
    send_item(CMD_UNUSED_LAST, '0, VALUE_ALL_ONES);
    send_item(scc_pkg::CMD_CLEAR, '0, '0);
    send_item(scc_pkg::CMD_GET, KEY_ALL_ONES, '0);
    wait_idle();
  endtask

  // A referenced entry gets its second chance, then the limit drops below the count.
  task automatic test_eviction();
    set_way_limit(4'd2);
    send_item(scc_pkg::CMD_PUT, key_pool[2], {$urandom(), $urandom()});
    send_item(scc_pkg::CMD_PUT, key_pool[3], {$urandom(), $urandom()});
    send_item(scc_pkg::CMD_GET, key_pool[2], '0);
    send_item(scc_pkg::CMD_PUT, key_pool[4], {$urandom(), $urandom()});
    send_item(scc_pkg::CMD_PROBE, key_pool[2], '0);
    send_item(scc_pkg::CMD_GET, key_pool[3], '0);
    wait_idle();
    set_way_limit(4'd8);
    send_item(scc_pkg::CMD_PUT, key_pool[5], {$urandom(), $urandom()});
    send_item(scc_pkg::CMD_PUT, key_pool[6], {$urandom(), $urandom()});
    wait_idle();
    set_way_limit(4'd2);
    send_item(scc_pkg::CMD_PUT, key_pool[7], {$urandom(), $urandom()});
    wait_idle();
  endtask

  task automatic test_random();
    logic [3:0] limits[12] = '{4'd15, 4'd8, 4'd1, 4'd5, 4'd0, 4'd3,
                               4'd2, 4'd9, 4'd6, 4'd4, 4'd7, 4'd8};
    logic [scc_pkg::CMD_BITS-1:0] cmd;
    logic [scc_pkg::KEY_BITS-1:0] key;
    int unsigned pick;
    int unsigned span;
    foreach (limits[p]) begin
      set_way_limit(limits[p]);
      max_gap = (p % 4 == 2) ? 0 : $urandom_range(1, 12);
      span = $urandom_range(3, 15);
      repeat (170) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = scc_pkg::CMD_PUT;
        else if (pick < 68) cmd = scc_pkg::CMD_GET;
        else if (pick < 80) cmd = scc_pkg::CMD_PROBE;
        else if (pick < 93) cmd = scc_pkg::CMD_DEL;
        else if (pick < 96) cmd = scc_pkg::CMD_CLEAR;
        else cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, span)];
        send_item(cmd, key, {$urandom(), $urandom()});
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    max_gap = 0;
    live_count = 0;
    way_limit = 4'd8;
    for (int i = 0; i < WAYS; i++) begin
      way_ok[i] = 1'b0;
      way_tag[i] = '0;
      way_data[i] = '0;
      way_ref[i] = 1'b0;
      age_order[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = KEY_ALL_ONES;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_ops();
    test_eviction();
    test_random();

    repeat (8) @(negedge clk_i);
    if (error_count == 0 && cache_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
